>>> rtl/vfrw_pkg.sv
// Shared types, constants and helpers of the variable frame read/write handler.
package vfrw_pkg;

  // Default sizes
  localparam int unsigned DEF_STORE_WORDS    = 4096;
  localparam int unsigned DEF_MAX_READ_WORDS = 28;

  // Widths
  localparam int unsigned WORD_W = 16;
  localparam int unsigned ADDR_W = 16;
  localparam int unsigned CNT_W  = 5;   // holds a read count up to 28

  // Frame bytes
  localparam logic [7:0] HDR_A   = 8'h5A;
  localparam logic [7:0] HDR_B   = 8'hA5;
  localparam logic [7:0] CMD_WR  = 8'h82;
  localparam logic [7:0] CMD_RD  = 8'h83;
  localparam logic [7:0] ACK_LEN = 8'h03;
  localparam logic [7:0] ACK_O   = 8'h4F;
  localparam logic [7:0] ACK_K   = 8'h4B;

  // Byte positions within replies
  localparam logic [2:0] ACK_LAST_POS = 3'd5;
  localparam logic [2:0] HDR_LAST_POS = 3'd6;

  // Receive parser phases
  typedef enum logic [2:0] {
    PH_HUNT_A = 3'd0,
    PH_HUNT_B = 3'd1,
    PH_LEN    = 3'd2,
    PH_CMD    = 3'd3,
    PH_ADDR_H = 3'd4,
    PH_ADDR_L = 3'd5,
    PH_DATA   = 3'd6,
    PH_COUNT  = 3'd7
  } phase_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_RX,
    ST_REDUCE,
    ST_ACK,
    ST_RD_HDR,
    ST_RD_HI,
    ST_RD_LO
  } state_e;

  // Write acknowledge byte at a given position
  function automatic logic [7:0] ack_byte(input logic [2:0] pos);
    logic [7:0] b;
    case (pos)
      3'd0:    b = HDR_A;
      3'd1:    b = HDR_B;
      3'd2:    b = ACK_LEN;
      3'd3:    b = CMD_WR;
      3'd4:    b = ACK_O;
      default: b = ACK_K;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/vfrw_store.sv
// Word store: single-port-write, registered-read memory with a clearing pass after reset.
module vfrw_store #(
  parameter int unsigned WORDS = vfrw_pkg::DEF_STORE_WORDS,
  parameter int unsigned IDX_W = $clog2(WORDS)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      we_i,
  input  logic [IDX_W-1:0]          waddr_i,
  input  logic [vfrw_pkg::WORD_W-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [IDX_W-1:0]          raddr_i,
  output logic [vfrw_pkg::WORD_W-1:0] rdata_o,
  output logic                      clr_busy_o
);
  import vfrw_pkg::*;

  logic [WORD_W-1:0] mem_q [WORDS];
  logic [WORD_W-1:0] rdata_q;
  logic              clr_busy_q, clr_busy_d;
  logic [IDX_W-1:0]  clr_idx_q, clr_idx_d;

  // Write port: zero fill while clearing, else the user write
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [WORD_W-1:0] wr_data;

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_idx_d  = clr_idx_q;
    if (clr_busy_q) begin
      clr_idx_d = clr_idx_q + 1'b1;
      if (clr_idx_q == IDX_W'(WORDS - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
    wr_en   = clr_busy_q | we_i;
    wr_addr = clr_busy_q ? clr_idx_q : waddr_i;
    wr_data = clr_busy_q ? '0 : wdata_i;
  end

  // Clearing sweep control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_idx_q  <= clr_idx_d;
    end
  end

  // Memory array
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o    = rdata_q;
  assign clr_busy_o = clr_busy_q;

endmodule

>>> rtl/vfrw_idx_mod.sv
// Reduction of a 16-bit word address modulo the store size by reciprocal multiply.
module vfrw_idx_mod #(
  parameter int unsigned WORDS = vfrw_pkg::DEF_STORE_WORDS,
  parameter int unsigned IDX_W = $clog2(WORDS)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [vfrw_pkg::ADDR_W-1:0] addr_i,
  output logic                        done_o,
  output logic [IDX_W-1:0]            idx_o
);
  import vfrw_pkg::*;

  // ceil(2^32 / WORDS) gives the exact quotient for every 16-bit address
  localparam longint unsigned RECIP_L = ((64'd1 << 32) + 64'(WORDS) - 64'd1) / 64'(WORDS);
  localparam logic [24:0] RECIP = 25'(RECIP_L);
  localparam logic [23:0] SPAN  = 24'(WORDS);

  logic              v1_q, v2_q;
  logic [ADDR_W-1:0] x_q, x_d;
  logic [7:0]        quo_q, quo_d;
  logic [39:0]       prod;
  logic [23:0]       qd;
  logic [ADDR_W-1:0] rem;

  // Stage one: quotient; stage two: remainder
  always_comb begin
    x_d   = start_i ? addr_i : x_q;
    prod  = 40'(x_q) * 40'(RECIP);
    quo_d = prod[39:32];
    qd    = 24'(quo_q) * SPAN;
    rem   = x_q - qd[ADDR_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    quo_q <= quo_d;
  end

  assign done_o = v2_q;
  assign idx_o  = rem[IDX_W-1:0];

endmodule

>>> rtl/variable_frame_read_write_handler.sv
// Top level: frame parser, reply sequencer and word store of the read/write handler.
//
//  channel   dir  tdata            tuser        tlast
//  s_axis    in   rx_byte[7:0]     op (1=tmo)   -
//  m_axis    out  tx_byte[7:0]     -            last reply byte
//
// One received word is taken per cycle while the parser waits for bytes.
// After the address of a read or data-carrying write frame, the store index is reduced.
// A write acknowledge streams 6 words, a read reply 7 + 2N words, one per
// cycle as the output register drains; m_axis_tready low holds the sequencer.
// After reset a clearing pass zeroes all STORE_WORDS words of the store first.
module variable_frame_read_write_handler #(
  parameter int unsigned STORE_WORDS    = vfrw_pkg::DEF_STORE_WORDS,
  parameter int unsigned MAX_READ_WORDS = vfrw_pkg::DEF_MAX_READ_WORDS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  input  logic       s_axis_tuser,   // [0] op
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] tx_byte
  output logic       m_axis_tlast
);
  import vfrw_pkg::*;

  localparam int unsigned IDX_W = $clog2(STORE_WORDS);

  state_e            state_q, state_d;
  phase_e            phase_q, phase_d;
  logic [7:0]        len_q, len_d;
  logic [7:0]        seen_q, seen_d;
  logic              is_read_q, is_read_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [7:0]        high_q, high_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [2:0]        pos_q, pos_d;
  logic [CNT_W-1:0]  nw_q, nw_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_data_q, out_data_d;
  logic              out_last_q, out_last_d;

  logic              accept;
  logic              load;
  logic              rx_ready;
  logic [7:0]        need;
  logic [7:0]        seen_inc;
  logic [IDX_W-1:0]  idx_inc;

  logic              mem_we;
  logic              mem_re;
  logic [IDX_W-1:0]  mem_raddr;
  logic [WORD_W-1:0] mem_rdata;
  logic              clr_busy;

  logic              mod_start;
  logic              mod_done;
  logic [IDX_W-1:0]  mod_idx;

  // Word store
  vfrw_store #(
    .WORDS (STORE_WORDS),
    .IDX_W (IDX_W)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .we_i       (mem_we),
    .waddr_i    (idx_q),
    .wdata_i    ({high_q, s_axis_tdata}),
    .re_i       (mem_re),
    .raddr_i    (mem_raddr),
    .rdata_o    (mem_rdata),
    .clr_busy_o (clr_busy)
  );

  // Address to store index
  vfrw_idx_mod #(
    .WORDS (STORE_WORDS),
    .IDX_W (IDX_W)
  ) u_idx_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .addr_i  ({addr_q[ADDR_W-1:8], s_axis_tdata}),
    .done_o  (mod_done),
    .idx_o   (mod_idx)
  );

  // Helpers: data bytes of a write frame, next index
  always_comb begin
    need     = (len_q < 8'd3) ? 8'd0 : ((len_q - 8'd3) & 8'hFE);
    seen_inc = seen_q + 8'd1;
    if (addr_q == 16'hFFFF || idx_q == IDX_W'(STORE_WORDS - 1)) begin
      idx_inc = '0;
    end else begin
      idx_inc = idx_q + 1'b1;
    end
  end

  // Next state and outputs
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    len_d       = len_q;
    seen_d      = seen_q;
    is_read_d   = is_read_q;
    addr_d      = addr_q;
    high_d      = high_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    nw_d        = nw_q;
    rem_d       = rem_q;
    load        = !out_valid_q || m_axis_tready;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    rx_ready    = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_raddr   = idx_q;
    mod_start   = 1'b0;
    accept      = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        if (!clr_busy) begin
          state_d = ST_RX;
        end
      end

      ST_RX: begin
        rx_ready = 1'b1;
        accept   = s_axis_tvalid;
        if (accept) begin
          if (s_axis_tuser) begin
            // timeout drops any partial frame
            phase_d = PH_HUNT_A;
            seen_d  = 8'd0;
          end else begin
            case (phase_q)
              PH_HUNT_A: begin
                if (s_axis_tdata == HDR_A) begin
                  phase_d = PH_HUNT_B;
                end
              end
              PH_HUNT_B: begin
                if (s_axis_tdata == HDR_B) begin
                  phase_d = PH_LEN;
                end else if (s_axis_tdata != HDR_A) begin
                  phase_d = PH_HUNT_A;
                end
              end
              PH_LEN: begin
                len_d   = s_axis_tdata;
                phase_d = PH_CMD;
              end
              PH_CMD: begin
                if (s_axis_tdata == CMD_WR) begin
                  is_read_d = 1'b0;
                  phase_d   = PH_ADDR_H;
                end else if (s_axis_tdata == CMD_RD) begin
                  is_read_d = 1'b1;
                  phase_d   = PH_ADDR_H;
                end else begin
                  phase_d = PH_HUNT_A;
                end
              end
              PH_ADDR_H: begin
                addr_d  = {s_axis_tdata, 8'd0};
                phase_d = PH_ADDR_L;
              end
              PH_ADDR_L: begin
                addr_d = {addr_q[ADDR_W-1:8], s_axis_tdata};
                if (is_read_q) begin
                  phase_d   = PH_COUNT;
                  mod_start = 1'b1;
                  state_d   = ST_REDUCE;
                end else begin
                  seen_d = 8'd0;
                  if (need == 8'd0) begin
                    // write without data: acknowledge at once
                    phase_d = PH_HUNT_A;
                    pos_d   = 3'd0;
                    state_d = ST_ACK;
                  end else begin
                    phase_d   = PH_DATA;
                    mod_start = 1'b1;
                    state_d   = ST_REDUCE;
                  end
                end
              end
              PH_DATA: begin
                if (!seen_q[0]) begin
                  high_d = s_axis_tdata;
                end else begin
                  mem_we = 1'b1;
                  idx_d  = idx_inc;
                  addr_d = addr_q + 16'd1;
                end
                seen_d = seen_inc;
                if (seen_inc >= need) begin
                  phase_d = PH_HUNT_A;
                  seen_d  = 8'd0;
                  pos_d   = 3'd0;
                  state_d = ST_ACK;
                end
              end
              PH_COUNT: begin
                // saturated word count, then the reply
                if (s_axis_tdata > 8'(MAX_READ_WORDS)) begin
                  nw_d = CNT_W'(MAX_READ_WORDS);
                end else begin
                  nw_d = s_axis_tdata[CNT_W-1:0];
                end
                phase_d = PH_HUNT_A;
                pos_d   = 3'd0;
                state_d = ST_RD_HDR;
              end
              default: begin
                phase_d = PH_HUNT_A;
              end
            endcase
          end
        end
      end

      ST_REDUCE: begin
        if (mod_done) begin
          idx_d   = mod_idx;
          state_d = ST_RX;
        end
      end

      ST_ACK: begin
        if (load) begin
          out_valid_d = 1'b1;
          out_data_d  = ack_byte(pos_q);
          out_last_d  = (pos_q == ACK_LAST_POS);
          pos_d       = pos_q + 3'd1;
          if (pos_q == ACK_LAST_POS) begin
            state_d = ST_RX;
          end
        end
      end

      ST_RD_HDR: begin
        // prefetch the first word while the header goes out
        mem_re = 1'b1;
        if (load) begin
          out_valid_d = 1'b1;
          out_last_d  = (pos_q == HDR_LAST_POS) && (nw_q == '0);
          case (pos_q)
            3'd0:    out_data_d = HDR_A;
            3'd1:    out_data_d = HDR_B;
            3'd2:    out_data_d = 8'({nw_q, 1'b0}) + 8'd4;
            3'd3:    out_data_d = CMD_RD;
            3'd4:    out_data_d = addr_q[15:8];
            3'd5:    out_data_d = addr_q[7:0];
            default: out_data_d = 8'(nw_q);
          endcase
          pos_d = pos_q + 3'd1;
          if (pos_q == HDR_LAST_POS) begin
            rem_d   = nw_q;
            state_d = (nw_q == '0) ? ST_RX : ST_RD_HI;
          end
        end
      end

      ST_RD_HI: begin
        if (load) begin
          out_valid_d = 1'b1;
          out_data_d  = mem_rdata[15:8];
          out_last_d  = 1'b0;
          state_d     = ST_RD_LO;
        end
      end

      ST_RD_LO: begin
        if (load) begin
          out_valid_d = 1'b1;
          out_data_d  = mem_rdata[7:0];
          out_last_d  = (rem_q == CNT_W'(1));
          rem_d       = rem_q - 1'b1;
          idx_d       = idx_inc;
          addr_d      = addr_q + 16'd1;
          // fetch the following word
          mem_re      = 1'b1;
          mem_raddr   = idx_inc;
          state_d     = (rem_q == CNT_W'(1)) ? ST_RX : ST_RD_HI;
        end
      end

      default: begin
        state_d = ST_RX;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      phase_q     <= PH_HUNT_A;
      len_q       <= 8'd0;
      seen_q      <= 8'd0;
      is_read_q   <= 1'b0;
      addr_q      <= '0;
      high_q      <= 8'd0;
      pos_q       <= 3'd0;
      nw_q        <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      len_q       <= len_d;
      seen_q      <= seen_d;
      is_read_q   <= is_read_d;
      addr_q      <= addr_d;
      high_q      <= high_d;
      pos_q       <= pos_d;
      nw_q        <= nw_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign s_axis_tready = rx_ready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking stream testbench of the variable frame read/write handler.
module tb;
  import vfrw_pkg::*;

  localparam int unsigned STORE_WORDS = DEF_STORE_WORDS;
  localparam int unsigned MAX_RD      = DEF_MAX_READ_WORDS;
  localparam int          LONG_HOLD   = 500;   // receiver hold-off, cycles
  localparam int          END_WAIT    = 300;   // quiet cycles after the last reply
  localparam int          PHASE_ITEMS = 18;    // frame bytes per idling phase
  localparam logic        OP_BYTE     = 1'b0;
  localparam logic        OP_TMO      = 1'b1;
  localparam logic [7:0]  CMD_BAD     = 8'h99;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
    logic       drain;   // hold this word back until all replies are out
  } rx_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } reply_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic       s_axis_tuser = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;

  variable_frame_read_write_handler #(
    .STORE_WORDS   (STORE_WORDS),
    .MAX_READ_WORDS(MAX_RD)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // Stimulus and expected reply bytes
  rx_item_t   rx_q[$];
  reply_t     reply_q[$];
  logic [7:0] frame_q[$];
  logic [15:0] addr_base[4];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int err_cnt = 0;
  int reply_idx = 0;

  // Parser shadow state
  phase_e      rx_phase = PH_HUNT_A;
  logic [7:0]  frame_len = '0;
  logic [7:0]  data_seen = '0;
  logic        read_cmd = 1'b0;
  logic [15:0] frame_addr = '0;
  logic [7:0]  high_byte = '0;
  bit   [15:0] word_store_model[STORE_WORDS];

  task automatic report_error(input string msg);
    err_cnt++;
    if (err_cnt <= 40) $display("ERROR at %0t: %s", $time, msg);
  endtask

  // Reply prediction
  function automatic void push_reply(input logic [7:0] d, input logic last);
    reply_q.push_back(reply_t'{data: d, last: last});
  endfunction

  function automatic int write_words(input logic [7:0] len);
    return (len < 8'd3) ? 0 : (int'(len) - 3) / 2;
  endfunction

  function automatic void push_ack();
    push_reply(HDR_A, 1'b0);
    push_reply(HDR_B, 1'b0);
    push_reply(ACK_LEN, 1'b0);
    push_reply(CMD_WR, 1'b0);
    push_reply(ACK_O, 1'b0);
    push_reply(ACK_K, 1'b1);
  endfunction

  function automatic void push_read_reply(input logic [7:0] req);
    logic [7:0]  n;
    logic [15:0] a;
    bit   [15:0] w;
    n = (req > MAX_RD) ? 8'(MAX_RD) : req;
    push_reply(HDR_A, 1'b0);
    push_reply(HDR_B, 1'b0);
    push_reply(8'(2 * n + 4), 1'b0);
    push_reply(CMD_RD, 1'b0);
    push_reply(frame_addr[15:8], 1'b0);
    push_reply(frame_addr[7:0], 1'b0);
    push_reply(n, n == 0);
    for (int i = 0; i < n; i++) begin
      a = frame_addr + 16'(i);
      w = word_store_model[a % STORE_WORDS];
      push_reply(w[15:8], 1'b0);
      push_reply(w[7:0], i == n - 1);
    end
  endfunction

  function automatic void predict_reply(input logic op, input logic [7:0] b);
    if (op == OP_TMO) begin
      rx_phase = PH_HUNT_A;
      data_seen = '0;
      return;
    end
    case (rx_phase)
      PH_HUNT_A: if (b == HDR_A) rx_phase = PH_HUNT_B;
      PH_HUNT_B: begin
        if (b == HDR_B) rx_phase = PH_LEN;
        else if (b != HDR_A) rx_phase = PH_HUNT_A;
      end
      PH_LEN: begin
        frame_len = b;
        rx_phase = PH_CMD;
      end
      PH_CMD: begin
        if (b == CMD_WR) begin
          read_cmd = 1'b0;
          rx_phase = PH_ADDR_H;
        end else if (b == CMD_RD) begin
          read_cmd = 1'b1;
          rx_phase = PH_ADDR_H;
        end else begin
          rx_phase = PH_HUNT_A;
        end
      end
      PH_ADDR_H: begin
        frame_addr = {b, 8'h00};
        rx_phase = PH_ADDR_L;
      end
      PH_ADDR_L: begin
        frame_addr[7:0] = b;
        if (read_cmd) begin
          rx_phase = PH_COUNT;
        end else begin
          data_seen = '0;
          if (write_words(frame_len) == 0) begin
            rx_phase = PH_HUNT_A;
            push_ack();
          end else begin
            rx_phase = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        if (!data_seen[0]) begin
          high_byte = b;
        end else begin
          word_store_model[frame_addr % STORE_WORDS] = {high_byte, b};
          frame_addr++;
        end
        data_seen++;
        if (int'(data_seen) >= 2 * write_words(frame_len)) begin
          rx_phase = PH_HUNT_A;
          data_seen = '0;
          push_ack();
        end
      end
      default: begin
        rx_phase = PH_HUNT_A;
        push_read_reply(b);
      end
    endcase
  endfunction

  // Frame builders
  function automatic void push_item(input logic op, input logic [7:0] d, input logic drain);
    rx_q.push_back(rx_item_t'{op: op, data: d, drain: drain});
  endfunction

  function automatic void build_head(input logic [7:0] len, input logic [7:0] cmd,
                                     input logic [15:0] a);
    frame_q = {};
    frame_q.push_back(HDR_A);
    frame_q.push_back(HDR_B);
    frame_q.push_back(len);
    frame_q.push_back(cmd);
    frame_q.push_back(a[15:8]);
    frame_q.push_back(a[7:0]);
  endfunction

  function automatic void build_write(input logic [15:0] a, input logic [7:0] len);
    build_head(len, CMD_WR, a);
    for (int i = 0; i < 2 * write_words(len); i++) frame_q.push_back(8'($urandom_range(255)));
  endfunction

  function automatic void build_read(input logic [15:0] a, input logic [7:0] len,
                                     input logic [7:0] cnt);
    build_head(len, CMD_RD, a);
    frame_q.push_back(cnt);
  endfunction

  // Emit the built frame whole, or cut short and followed by a timeout or junk
  function automatic int emit_frame(input bit cut_short, input logic drain);
    int n;
    n = cut_short ? $urandom_range(frame_q.size() - 1, 1) : frame_q.size();
    for (int i = 0; i < n; i++) push_item(OP_BYTE, frame_q[i], drain && i == 0);
    if (cut_short) begin
      if ($urandom_range(9) < 7) push_item(OP_TMO, 8'($urandom_range(255)), 1'b0);
      else push_item(OP_BYTE, 8'($urandom_range(255)), 1'b0);
    end
    return n;
  endfunction

  function automatic logic [15:0] pick_addr();
    case ($urandom_range(4))
      0:       return 16'($urandom_range(16'hFFFF));
      1:       return 16'hFFFF - 16'($urandom_range(3));
      default: return addr_base[$urandom_range(3)] + 16'($urandom_range(7));
    endcase
  endfunction

  function automatic logic [7:0] pick_count();
    int r;
    r = $urandom_range(9);
    if (r < 6) return 8'($urandom_range(6));
    if (r < 8) return 8'($urandom_range(40, 20));
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] pick_write_len();
    if ($urandom_range(19) == 0) return 8'($urandom_range(2));
    if ($urandom_range(29) == 0) return 8'($urandom_range(255));
    return 8'(2 * $urandom_range(6) + 3 + $urandom_range(1));
  endfunction

  // One random frame; returns the frame bytes queued (noise counts as none)
  function automatic int random_frame();
    int          kind;
    logic [7:0]  cmd;
    logic        drain;
    kind = $urandom_range(99);
    drain = ($urandom_range(19) == 0);
    if (kind < 40) begin
      build_write(pick_addr(), pick_write_len());
      return emit_frame(1'b0, drain);
    end else if (kind < 75) begin
      build_read(pick_addr(), 8'($urandom_range(255)), pick_count());
      return emit_frame(1'b0, drain);
    end else if (kind < 85) begin
      if ($urandom_range(1)) build_write(pick_addr(), pick_write_len());
      else build_read(pick_addr(), 8'($urandom_range(255)), pick_count());
      return emit_frame(1'b1, drain);
    end else if (kind < 90) begin
      cmd = 8'($urandom_range(255));
      if (cmd == CMD_WR || cmd == CMD_RD) cmd = CMD_BAD;
      build_head(8'($urandom_range(255)), cmd, pick_addr());
      frame_q = frame_q[0:3];
      return emit_frame(1'b0, drain);
    end
    // line noise and idle timeouts
    for (int i = 0; i < $urandom_range(4, 1); i++)
      push_item(logic'($urandom_range(1)), 8'($urandom_range(255)), 1'b0);
    return 0;
  endfunction

  // Edge cases: timeout, resync, short and odd lengths, wrap, saturation, bad command
  function automatic void push_directed();
    push_item(OP_TMO, 8'hFF, 1'b0);
    push_item(OP_BYTE, HDR_A, 1'b0);
    build_write(16'hFFFF, 8'd2);
    void'(emit_frame(1'b0, 1'b0));
    build_head(8'd6, CMD_WR, 16'hFFFF);
    frame_q.push_back(8'h00);
    frame_q.push_back(8'hFF);
    void'(emit_frame(1'b0, 1'b0));
    build_read(16'h0FFF, 8'h00, 8'hFF);
    void'(emit_frame(1'b0, 1'b0));
    build_head(8'd5, CMD_BAD, 16'h0000);
    frame_q = frame_q[0:3];
    void'(emit_frame(1'b0, 1'b0));
    push_item(OP_BYTE, HDR_A, 1'b0);
    push_item(OP_BYTE, HDR_B, 1'b0);
    push_item(OP_BYTE, 8'd7, 1'b0);
    push_item(OP_TMO, 8'h00, 1'b0);
    push_item(OP_BYTE, HDR_A, 1'b0);
    push_item(OP_BYTE, 8'h00, 1'b0);
  endfunction

  // Input driver: predicts on each accepted word, then offers the next one
  always @(posedge clk_i) begin : drive_rx
    logic     free;
    rx_item_t item;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      free = !s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        predict_reply(s_axis_tuser, s_axis_tdata);
        free = 1'b1;
      end
      if (free) begin
        if (rx_q.size() != 0 && !(rx_q[0].drain && reply_q.size() != 0) &&
            $urandom_range(99) >= send_idle_pct) begin
          item = rx_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= item.data;
          s_axis_tuser  <= item.op;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Reply monitor and receiver back-pressure
  always @(posedge clk_i) begin : watch_tx
    reply_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (reply_q.size() == 0) begin
        report_error($sformatf("reply byte %0d: %h with nothing pending",
                               reply_idx, m_axis_tdata));
      end else begin
        want = reply_q.pop_front();
        if (m_axis_tdata !== want.data)
          report_error($sformatf("reply byte %0d: data %h, wanted %h",
                                 reply_idx, m_axis_tdata, want.data));
        if (m_axis_tlast !== want.last)
          report_error($sformatf("reply byte %0d: last %b, wanted %b",
                                 reply_idx, m_axis_tlast, want.last));
      end
      reply_idx <= reply_idx + 1;
    end
    if (hold_seq != hold_seen) begin
      hold_seen     <= hold_seq;
      hold_left     <= LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic wait_drained();
    while (rx_q.size() != 0 || s_axis_tvalid || reply_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct);
    int got;
    got = 0;
    @(negedge clk_i);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    while (got < PHASE_ITEMS) got += random_frame();
    wait_drained();
  endtask

  // Main sequence
  initial begin
    addr_base[0] = 16'h0000;
    addr_base[1] = 16'h0FFC;
    addr_base[2] = 16'h1000;   // aliases the bottom of the store
    addr_base[3] = 16'($urandom_range(16'hFFFF));
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    push_directed();
    wait_drained();

    run_phase(0, 0);
    run_phase(83, 0);
    run_phase(0, 83);
    run_phase(9, 9);

    // Fill the block against a long receiver hold-off, then pause for drain
    @(negedge clk_i);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_seq       = hold_seq + 1;
    for (int i = 0; i < 8; i++) begin
      build_read(pick_addr(), 8'($urandom_range(255)), 8'(MAX_RD));
      void'(emit_frame(1'b0, 1'b0));
    end
    build_write(pick_addr(), 8'd7);
    void'(emit_frame(1'b0, 1'b1));
    build_read({frame_q[4], frame_q[5]}, 8'd0, 8'd2);
    void'(emit_frame(1'b0, 1'b0));
    wait_drained();

    run_phase(0, 0);

    repeat (END_WAIT) @(negedge clk_i);
    if (err_cnt == 0 && reply_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
